### rtl/ichc_pkg.sv
// Package: shared types, constants and address helpers of the two-level cache model.
`default_nettype none
package ichc_pkg;

    localparam int L1_LINES   = 256;
    localparam int L2_LINES   = 1024;
    localparam int L1_AW      = 8;
    localparam int L2_AW      = 10;
    localparam int WAY_CAP    = 3;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BLOCK    = 3'd0,
        CFG_L1_SIZE  = 3'd1,
        CFG_L2_SIZE  = 3'd2,
        CFG_L1_WAYS  = 3'd3,
        CFG_L2_WAYS  = 3'd4,
        CFG_WR_ALLOC = 3'd5
    } ichc_cfg_idx_t;

    typedef struct packed {
        logic [31:0] address;
        logic        command;
    } ichc_req_t;

    typedef struct packed {
        logic        l1_hit;
        logic        l2_accessed;
        logic        l2_hit;
        logic        l1_dirty_evicted;
        logic        memory_writeback;
        logic [31:0] writeback_address;
    } ichc_rsp_t;

    // One stored line of either level
    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic [31:0] tag;
        logic [31:0] stamp;
    } ichc_entry_t;

    // Effective geometry after saturation
    typedef struct packed {
        logic [3:0] blk;
        logic [3:0] l1_sets;
        logic [1:0] l1_ways;
        logic [3:0] l2_sets;
        logic [1:0] l2_ways;
        logic       wr_alloc;
    } ichc_geom_t;

    function automatic logic [9:0] f_set(logic [31:0] a, logic [3:0] blk, logic [3:0] sets);
        logic [31:0] s;
        s = a >> blk;
        return s[9:0] & 10'((11'd1 << sets) - 11'd1);
    endfunction

    function automatic logic [31:0] f_tag(logic [31:0] a, logic [3:0] blk, logic [3:0] sets);
        return a >> (5'(blk) + 5'(sets));
    endfunction

    function automatic logic [31:0] f_vaddr(logic [31:0] tag, logic [9:0] set,
                                            logic [3:0] blk, logic [3:0] sets);
        logic [63:0] v;
        v = ((64'(tag) << sets) | 64'(set)) << blk;
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

### rtl/ichc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ichc_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 66,
    parameter int AW    = 8
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/ichc_cfg.sv
// Configuration registers and saturated geometry of both cache levels.
`default_nettype none
module ichc_cfg import ichc_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       we,
    input  wire logic [2:0] index,
    input  wire logic [4:0] data,
    output ichc_geom_t      geom
);

    logic [3:0] blk_reg;
    logic [4:0] l1_size_reg;
    logic [4:0] l2_size_reg;
    logic [1:0] l1_ways_reg;
    logic [1:0] l2_ways_reg;
    logic       wa_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_reg     <= 4'd4;
            l1_size_reg <= 5'd10;
            l2_size_reg <= 5'd12;
            l1_ways_reg <= 2'd1;
            l2_ways_reg <= 2'd2;
            wa_reg      <= 1'b1;
        end
        else if (we)
        begin
            unique case (index)
                CFG_BLOCK:    blk_reg     <= data[3:0];
                CFG_L1_SIZE:  l1_size_reg <= data;
                CFG_L2_SIZE:  l2_size_reg <= data;
                CFG_L1_WAYS:  l1_ways_reg <= data[1:0];
                CFG_L2_WAYS:  l2_ways_reg <= data[1:0];
                CFG_WR_ALLOC: wa_reg      <= data[0];
                default:      ;
            endcase
        end
    end

    // saturate lines and ways per level
    logic [4:0] l1_lines;
    logic [4:0] l2_lines;
    logic [4:0] l1_w;
    logic [4:0] l2_w;

    always_comb
    begin
        l1_lines = (l1_size_reg > 5'(blk_reg)) ? l1_size_reg - 5'(blk_reg) : 5'd0;
        l2_lines = (l2_size_reg > 5'(blk_reg)) ? l2_size_reg - 5'(blk_reg) : 5'd0;
        if (l1_lines > 5'(L1_AW)) l1_lines = 5'(L1_AW);
        if (l2_lines > 5'(L2_AW)) l2_lines = 5'(L2_AW);
        l1_w = 5'(l1_ways_reg);
        l2_w = 5'(l2_ways_reg);
        if (l1_w > l1_lines) l1_w = l1_lines;
        if (l2_w > l2_lines) l2_w = l2_lines;
        if (l1_w > 5'(WAY_CAP)) l1_w = 5'(WAY_CAP);
        if (l2_w > 5'(WAY_CAP)) l2_w = 5'(WAY_CAP);
        geom.blk      = blk_reg;
        geom.l1_ways  = l1_w[1:0];
        geom.l2_ways  = l2_w[1:0];
        geom.l1_sets  = 4'(l1_lines - l1_w);
        geom.l2_sets  = 4'(l2_lines - l2_w);
        geom.wr_alloc = wa_reg;
    end

endmodule
`default_nettype wire

### rtl/two_level_inclusive_cache_model.sv
// Top level: access sequencer over the L1 and L2 tag memories.
`default_nettype none
// Tag-only model of an inclusive two-level write-back cache with true LRU. Each access
// beat on req yields one rsp beat. A sequencer walks the ways of a set one at a time
// through a tag RAM with registered read data: each way examined is read and then
// compared (ST_RD, ST_CMP), each set walk ends in one update state (ST_ACT), and a hit
// ends the walk at that way. An access makes one to four set walks (L1 lookup, L2
// lookup of a dirty L1 victim or of a write without allocation, L2 lookup, L1
// invalidation of an L2 victim) and passes through the accept (ST_IDLE) and output
// (ST_OUT) states of the handoff. A result that waits on rsp_ready holds the sequencer
// in handoff and the input stays blocked. After reset a clearing pass zeroes both tag
// stores before the first access is taken; configuration writes are taken at any time
// and must only be made while idle.
module two_level_inclusive_cache_model import ichc_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire ichc_req_t  req,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output ichc_rsp_t       rsp,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [4:0] cfg_data
);

    typedef enum logic [5:0] {
        ST_CLR  = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_RD   = 6'b000100,
        ST_CMP  = 6'b001000,
        ST_ACT  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    typedef enum logic [4:0] {
        PH_L1A = 5'b00001,
        PH_L2W = 5'b00010,
        PH_L2V = 5'b00100,
        PH_L2A = 5'b01000,
        PH_L1I = 5'b10000
    } phase_t;

    ichc_geom_t geom;

    assign cfg_ready = 1'b1;

    ichc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_valid),
        .index (cfg_index),
        .data  (cfg_data),
        .geom  (geom)
    );

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic        level_reg, level_next;
    logic [31:0] scan_addr_reg, scan_addr_next;
    logic [2:0]  way_reg, way_next;
    logic        hit_reg, hit_next;
    logic [9:0]  hit_idx_reg, hit_idx_next;
    ichc_entry_t hit_ent_reg, hit_ent_next;
    logic        free_reg, free_next;
    logic [9:0]  pick_idx_reg, pick_idx_next;
    logic [31:0] pick_stamp_reg, pick_stamp_next;
    logic [31:0] pick_tag_reg, pick_tag_next;
    logic        pick_dirty_reg, pick_dirty_next;
    logic [31:0] ncnt_reg, ncnt_next;
    logic [31:0] fcnt_reg, fcnt_next;
    logic [9:0]  clr_reg, clr_next;
    ichc_req_t   cur_reg, cur_next;
    ichc_rsp_t   res_reg, res_next;
    logic        rsp_valid_reg, rsp_valid_next;
    ichc_rsp_t   rsp_reg, rsp_next;

    // memory ports
    logic              l1_we, l2_we;
    logic [L1_AW-1:0]  l1_waddr;
    logic [L2_AW-1:0]  l2_waddr;
    ichc_entry_t       l1_wdata, l2_wdata;
    ichc_entry_t       l1_rdata, l2_rdata;
    logic [9:0]        idx_w;

    ichc_ram #(.DEPTH(L1_LINES), .WIDTH($bits(ichc_entry_t)), .AW(L1_AW)) u_l1_ram (
        .clk   (clk),
        .we    (l1_we),
        .waddr (l1_waddr),
        .wdata (l1_wdata),
        .raddr (idx_w[L1_AW-1:0]),
        .rdata (l1_rdata)
    );

    ichc_ram #(.DEPTH(L2_LINES), .WIDTH($bits(ichc_entry_t)), .AW(L2_AW)) u_l2_ram (
        .clk   (clk),
        .we    (l2_we),
        .waddr (l2_waddr),
        .wdata (l2_wdata),
        .raddr (idx_w[L2_AW-1:0]),
        .rdata (l2_rdata)
    );

    // geometry and set/tag of the address under scan
    logic [3:0]  cur_sets;
    logic [1:0]  cur_ways;
    logic [9:0]  sc_set;
    logic [31:0] sc_tag;
    logic [2:0]  ways_m1;
    ichc_entry_t rd;
    logic        e_hit;

    always_comb
    begin
        cur_sets = level_reg ? geom.l2_sets : geom.l1_sets;
        cur_ways = level_reg ? geom.l2_ways : geom.l1_ways;
        sc_set   = f_set(scan_addr_reg, geom.blk, cur_sets);
        sc_tag   = f_tag(scan_addr_reg, geom.blk, cur_sets);
        idx_w    = (10'(way_reg) << cur_sets) | sc_set;
        ways_m1  = 3'((4'd1 << cur_ways) - 4'd1);
        rd       = level_reg ? l2_rdata : l1_rdata;
        e_hit    = rd.valid && (rd.tag == sc_tag);
    end

    // sequencer
    logic        sc_go;
    logic        sc_lvl;
    logic [31:0] sc_a;
    phase_t      sc_ph;
    logic [31:0] va;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        level_next      = level_reg;
        scan_addr_next  = scan_addr_reg;
        way_next        = way_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_ent_next    = hit_ent_reg;
        free_next       = free_reg;
        pick_idx_next   = pick_idx_reg;
        pick_stamp_next = pick_stamp_reg;
        pick_tag_next   = pick_tag_reg;
        pick_dirty_next = pick_dirty_reg;
        ncnt_next       = ncnt_reg;
        fcnt_next       = fcnt_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        res_next        = res_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        l1_we           = 1'b0;
        l2_we           = 1'b0;
        l1_waddr        = hit_idx_reg[L1_AW-1:0];
        l2_waddr        = hit_idx_reg;
        l1_wdata        = '0;
        l2_wdata        = '0;
        sc_go           = 1'b0;
        sc_lvl          = 1'b0;
        sc_a            = cur_reg.address;
        sc_ph           = PH_L1A;
        va              = '0;

        unique case (state_reg)
            // zero both tag stores after reset
            ST_CLR:
            begin
                l1_we    = 1'b1;
                l2_we    = 1'b1;
                l1_waddr = clr_reg[L1_AW-1:0];
                l2_waddr = clr_reg;
                clr_next = clr_reg + 10'd1;
                if (clr_reg == 10'(L2_LINES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cur_next = req;
                    res_next = '0;
                    sc_go    = 1'b1;
                    sc_lvl   = 1'b0;
                    sc_a     = req.address;
                    sc_ph    = PH_L1A;
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            // examine one way: hit check and LRU victim tracking
            ST_CMP:
            begin
                if (e_hit)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_w[L2_AW-1:0];
                    hit_ent_next = rd;
                    state_next   = ST_ACT;
                end
                else
                begin
                    if (!free_reg)
                    begin
                        if (!rd.valid)
                        begin
                            free_next     = 1'b1;
                            pick_idx_next = idx_w[L2_AW-1:0];
                        end
                        else if (way_reg == 3'd0 || rd.stamp < pick_stamp_reg)
                        begin
                            pick_idx_next   = idx_w[L2_AW-1:0];
                            pick_stamp_next = rd.stamp;
                            pick_tag_next   = rd.tag;
                            pick_dirty_next = rd.dirty;
                        end
                    end
                    if (way_reg == ways_m1)
                    begin
                        state_next = ST_ACT;
                    end
                    else
                    begin
                        way_next   = way_reg + 3'd1;
                        state_next = ST_RD;
                    end
                end
            end
            // act on the finished set walk
            ST_ACT:
            begin
                state_next = ST_OUT;
                unique case (phase_reg)
                    PH_L1A:
                    begin
                        if (hit_reg)
                        begin
                            l1_we          = 1'b1;
                            l1_wdata       = hit_ent_reg;
                            l1_wdata.dirty = hit_ent_reg.dirty | cur_reg.command;
                            l1_wdata.stamp = ncnt_reg;
                            ncnt_next      = ncnt_reg + 32'd1;
                            res_next.l1_hit = 1'b1;
                        end
                        else if (cur_reg.command && !geom.wr_alloc)
                        begin
                            res_next.l2_accessed = 1'b1;
                            sc_go  = 1'b1;
                            sc_lvl = 1'b1;
                            sc_ph  = PH_L2W;
                        end
                        else
                        begin
                            l1_we     = 1'b1;
                            l1_waddr  = pick_idx_reg[L1_AW-1:0];
                            l1_wdata  = '{valid: 1'b1, dirty: cur_reg.command,
                                          tag: sc_tag, stamp: ncnt_reg};
                            ncnt_next = ncnt_reg + 32'd1;
                            res_next.l2_accessed = 1'b1;
                            sc_go  = 1'b1;
                            sc_lvl = 1'b1;
                            if (!free_reg && pick_dirty_reg)
                            begin
                                sc_a  = f_vaddr(pick_tag_reg, sc_set, geom.blk, cur_sets);
                                sc_ph = PH_L2V;
                            end
                            else
                            begin
                                sc_ph = PH_L2A;
                            end
                        end
                    end
                    PH_L2W:
                    begin
                        if (hit_reg)
                        begin
                            l2_we          = 1'b1;
                            l2_wdata       = hit_ent_reg;
                            l2_wdata.dirty = 1'b1;
                            l2_wdata.stamp = fcnt_reg;
                            fcnt_next      = fcnt_reg + 32'd1;
                            res_next.l2_hit = 1'b1;
                        end
                    end
                    PH_L2V:
                    begin
                        if (hit_reg)
                        begin
                            l2_we          = 1'b1;
                            l2_wdata       = hit_ent_reg;
                            l2_wdata.dirty = 1'b1;
                            l2_wdata.stamp = fcnt_reg;
                            fcnt_next      = fcnt_reg + 32'd1;
                            res_next.l1_dirty_evicted = 1'b1;
                        end
                        sc_go  = 1'b1;
                        sc_lvl = 1'b1;
                        sc_ph  = PH_L2A;
                    end
                    PH_L2A:
                    begin
                        fcnt_next = fcnt_reg + 32'd1;
                        l2_we     = 1'b1;
                        if (hit_reg)
                        begin
                            l2_wdata       = hit_ent_reg;
                            l2_wdata.dirty = hit_ent_reg.dirty | cur_reg.command;
                            l2_wdata.stamp = fcnt_reg;
                            res_next.l2_hit = 1'b1;
                        end
                        else
                        begin
                            l2_waddr = pick_idx_reg;
                            l2_wdata = '{valid: 1'b1, dirty: cur_reg.command,
                                         tag: sc_tag, stamp: fcnt_reg};
                            if (!free_reg)
                            begin
                                va = f_vaddr(pick_tag_reg, sc_set, geom.blk, cur_sets);
                                if (pick_dirty_reg)
                                begin
                                    res_next.memory_writeback  = 1'b1;
                                    res_next.writeback_address = va;
                                end
                                sc_go  = 1'b1;
                                sc_lvl = 1'b0;
                                sc_a   = va;
                                sc_ph  = PH_L1I;
                            end
                        end
                    end
                    PH_L1I:
                    begin
                        if (hit_reg)
                        begin
                            l1_we          = 1'b1;
                            l1_wdata       = hit_ent_reg;
                            l1_wdata.valid = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            // hand the result to the output register
            ST_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: ;
        endcase

        // launch a set walk
        if (sc_go)
        begin
            level_next     = sc_lvl;
            scan_addr_next = sc_a;
            phase_next     = sc_ph;
            way_next       = 3'd0;
            hit_next       = 1'b0;
            free_next      = 1'b0;
            state_next     = ST_RD;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            phase_reg     <= PH_L1A;
            clr_reg       <= '0;
            ncnt_reg      <= '0;
            fcnt_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            level_reg     <= 1'b0;
            way_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_reg       <= clr_next;
            ncnt_reg      <= ncnt_next;
            fcnt_reg      <= fcnt_next;
            rsp_valid_reg <= rsp_valid_next;
            level_reg     <= level_next;
            way_reg       <= way_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        scan_addr_reg  <= scan_addr_next;
        hit_idx_reg    <= hit_idx_next;
        hit_ent_reg    <= hit_ent_next;
        pick_idx_reg   <= pick_idx_next;
        pick_stamp_reg <= pick_stamp_next;
        pick_tag_reg   <= pick_tag_next;
        pick_dirty_reg <= pick_dirty_next;
        cur_reg        <= cur_next;
        res_reg        <= res_next;
        rsp_reg        <= rsp_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // no access is taken during the clearing pass
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR) |-> !req_ready)
        else $error("access taken during clearing pass");

    // tag stores are only written when clearing or updating after a set walk
    a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (l1_we || l2_we) |-> (state_reg == ST_ACT || state_reg == ST_CLR))
        else $error("tag store written outside update slot");

    // a new result only comes from the handoff state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside handoff");

    // an L1 hit never reaches L2
    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.l1_hit && rsp_reg.l2_accessed))
        else $error("L1 hit also looked up L2");

endmodule
`default_nettype wire
